// ===== sv/qce_pkg.sv =====
// Shared types and constants for the quoted column extractor.
// No dependencies; imported by every module of the block.
package qce_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned INDEX_W = 3;

    localparam logic [BYTE_W-1:0] QUOTE_BYTE = 8'h22;

    // Configuration register indexes
    localparam logic [INDEX_W-1:0] REG_TARGET_COLUMN = 3'd0;
    localparam logic [INDEX_W-1:0] REG_DELIM_A       = 3'd1;
    localparam logic [INDEX_W-1:0] REG_DELIM_B       = 3'd2;
    localparam logic [INDEX_W-1:0] REG_DELIM_C       = 3'd3;
    localparam logic [INDEX_W-1:0] REG_DELIM_D       = 3'd4;

    // Configuration reset values
    localparam logic [BYTE_W-1:0] RST_TARGET_COLUMN = 8'd0;
    localparam logic [BYTE_W-1:0] RST_DELIM_A       = 8'd32;
    localparam logic [BYTE_W-1:0] RST_DELIM_B       = 8'd9;
    localparam logic [BYTE_W-1:0] RST_DELIM_C       = 8'd0;
    localparam logic [BYTE_W-1:0] RST_DELIM_D       = 8'd0;

    // Number of delimiter slots that exist as registers
    localparam int unsigned NUM_SLOTS = 4;

    // Result status codes
    localparam logic [1:0] ST_BYTE  = 2'd0;
    localparam logic [1:0] ST_FOUND = 2'd1;
    localparam logic [1:0] ST_ERROR = 2'd2;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_USKIP  = 3'd1,
        PH_QSKIP  = 3'd2,
        PH_QFIRST = 3'd3,
        PH_QIN    = 3'd4,
        PH_TCOL   = 3'd5,
        PH_DONE   = 3'd6
    } phase_t;

    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] ch;
        logic [1:0]        status;
    } result_t;

endpackage

// ===== sv/quoted_column_extractor_core.sv =====
// Top level of the quoted column extractor: input register, scanner, result register.
// Depends on qce_pkg, qce_delim_match, qce_scan and qce_out_reg.
//
// Usage:
//   Input channel (in_valid / in_stall, ch, end_of_line) carries one byte of a
//   text line per beat; a beat with end_of_line set closes the line and its ch
//   is ignored. Output channel (out_valid / out_stall, out_ch, status) carries
//   the bytes of the selected column with quotes removed (status 0), then one
//   closing beat per line: status 1 found or status 2 error, out_ch zero.
//   On an error the receiver drops the column bytes it has already taken.
//   Configuration channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   target_column (0) and delim_a..delim_d (1..4); other indexes are dropped.
//   cfg_ready is always high; write only while the block is idle.
// Timing:
//   One byte per cycle sustained while the receiver does not stall. A beat
//   lands in the input register, then the scanner's single pass of compares
//   feeds the result register, where its result becomes visible.
// Reset:
//   rst_n clears both registers' valid flags, puts the scan at the start of a
//   line and restores the register defaults (column 0, space and tab).
// Stall:
//   A stalled result holds in the result register; the input register keeps
//   its byte and in_stall rises, so no beat is lost while the receiver waits.
module quoted_column_extractor_core #(
    parameter int unsigned NUM_DELIMS = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [qce_pkg::BYTE_W-1:0]   ch,
    input  logic                         end_of_line,
    // output channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [qce_pkg::BYTE_W-1:0]   out_ch,
    output logic [1:0]                   status,
    // configuration channel
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [qce_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [qce_pkg::BYTE_W-1:0]   cfg_data
);
    import qce_pkg::*;

    // Configuration registers
    logic [BYTE_W-1:0] target_column_reg;
    logic [BYTE_W-1:0] delim_a_reg;
    logic [BYTE_W-1:0] delim_b_reg;
    logic [BYTE_W-1:0] delim_c_reg;
    logic [BYTE_W-1:0] delim_d_reg;

    // Input register
    logic              in_vld_reg;
    logic              in_vld_next;
    logic [BYTE_W-1:0] ch_reg;
    logic              eol_reg;

    logic              in_accept;
    logic              out_free;
    logic              step;
    logic              is_delim;
    result_t           res;

    logic [NUM_SLOTS-1:0][BYTE_W-1:0]  cfg_slots;
    logic [NUM_DELIMS-1:0][BYTE_W-1:0] slots;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_column_reg <= RST_TARGET_COLUMN;
            delim_a_reg       <= RST_DELIM_A;
            delim_b_reg       <= RST_DELIM_B;
            delim_c_reg       <= RST_DELIM_C;
            delim_d_reg       <= RST_DELIM_D;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TARGET_COLUMN: target_column_reg <= cfg_data;
                REG_DELIM_A:       delim_a_reg       <= cfg_data;
                REG_DELIM_B:       delim_b_reg       <= cfg_data;
                REG_DELIM_C:       delim_c_reg       <= cfg_data;
                REG_DELIM_D:       delim_d_reg       <= cfg_data;
                default:           ;   // drop writes past the register list
            endcase
        end
    end

    // Slots past the fourth do not exist and read as unused
    assign cfg_slots = {delim_d_reg, delim_c_reg, delim_b_reg, delim_a_reg};

    for (genvar i = 0; i < NUM_DELIMS; i++)
    begin : g_slot
        if (i < NUM_SLOTS)
        begin : g_used
            assign slots[i] = cfg_slots[i];
        end
        else
        begin : g_none
            assign slots[i] = '0;
        end
    end

    // Advance the input beat whenever the result register can take its result.
    // A beat that yields no result also waits here, keeping results in order.
    assign out_free  = !out_valid || !out_stall;
    assign step      = in_vld_reg && out_free;
    assign in_stall  = in_vld_reg && !out_free;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (step)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ch_reg  <= ch;
            eol_reg <= end_of_line;
        end
    end

    qce_delim_match #(
        .NUM_DELIMS (NUM_DELIMS)
    ) u_match (
        .ch       (ch_reg),
        .slots    (slots),
        .is_delim (is_delim)
    );

    qce_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .ch            (ch_reg),
        .eol           (eol_reg),
        .is_delim      (is_delim),
        .target_column (target_column_reg),
        .res           (res)
    );

    qce_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_ch    (out_ch),
        .status    (status)
    );

endmodule

// ===== sv/qce_delim_match.sv =====
// Parallel compare of one byte against the delimiter slots.
// Depends on qce_pkg.
module qce_delim_match #(
    parameter int unsigned NUM_DELIMS = 4
) (
    input  logic [qce_pkg::BYTE_W-1:0]                  ch,
    input  logic [NUM_DELIMS-1:0][qce_pkg::BYTE_W-1:0]  slots,
    output logic                                        is_delim
);
    import qce_pkg::*;

    logic [NUM_DELIMS-1:0] hit;

    // A zero slot is unused and never matches
    always_comb
    begin
        for (int i = 0; i < NUM_DELIMS; i++)
        begin
            hit[i] = (slots[i] != '0) && (slots[i] == ch);
        end
    end

    assign is_delim = |hit;

endmodule

// ===== sv/qce_scan.sv =====
// Line scanner state machine: phase and column count, one byte per step.
// Depends on qce_pkg.
module qce_scan (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [qce_pkg::BYTE_W-1:0]  ch,
    input  logic                        eol,
    input  logic                        is_delim,
    input  logic [qce_pkg::COUNT_W-1:0] target_column,
    output qce_pkg::result_t            res
);
    import qce_pkg::*;

    phase_t             phase_reg;
    phase_t             phase_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               is_quote;

    assign is_quote = (ch == QUOTE_BYTE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        if (eol)
        begin
            phase_next = PH_SKIP;
            count_next = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_USKIP:
                begin
                    if (is_delim)
                    begin
                        count_next = count_reg + 1'b1;
                        phase_next = PH_SKIP;
                    end
                end
                PH_QSKIP:
                begin
                    if (is_quote)
                    begin
                        count_next = count_reg + 1'b1;
                        phase_next = PH_SKIP;
                    end
                end
                PH_QFIRST:
                begin
                    phase_next = is_quote ? PH_DONE : PH_QIN;
                end
                PH_QIN:
                begin
                    if (is_quote)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_TCOL:
                begin
                    if (is_delim)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE:
                begin
                    phase_next = PH_DONE;
                end
                default:
                begin
                    if (is_delim)
                    begin
                        phase_next = PH_SKIP;
                    end
                    else if (count_reg == target_column)
                    begin
                        phase_next = is_quote ? PH_QFIRST : PH_TCOL;
                    end
                    else
                    begin
                        phase_next = is_quote ? PH_QSKIP : PH_USKIP;
                    end
                end
            endcase
        end
    end

    // Outputs
    always_comb
    begin
        res.emit   = 1'b0;
        res.ch     = '0;
        res.status = ST_BYTE;
        unique case (phase_reg) inside
            PH_USKIP, PH_QSKIP:
            begin
                if (eol)
                begin
                    res.emit   = 1'b1;
                    res.status = ST_ERROR;
                end
            end
            PH_QFIRST:
            begin
                res.emit = 1'b1;
                if (eol || is_quote)
                begin
                    res.status = ST_ERROR;
                end
                else
                begin
                    res.ch = ch;
                end
            end
            PH_QIN:
            begin
                res.emit = 1'b1;
                if (eol)
                begin
                    res.status = ST_ERROR;
                end
                else if (is_quote)
                begin
                    res.status = ST_FOUND;
                end
                else
                begin
                    res.ch = ch;
                end
            end
            PH_TCOL:
            begin
                res.emit = 1'b1;
                if (eol || is_delim)
                begin
                    res.status = ST_FOUND;
                end
                else
                begin
                    res.ch = ch;
                end
            end
            PH_DONE:
            begin
                res.emit = 1'b0;
            end
            default:
            begin
                if (eol)
                begin
                    res.emit   = 1'b1;
                    res.status = ST_ERROR;
                end
                else if (!is_delim && (count_reg == target_column) && !is_quote)
                begin
                    res.emit = 1'b1;
                    res.ch   = ch;
                end
            end
        endcase
    end

endmodule

// ===== sv/qce_out_reg.sv =====
// Result register on the output channel; holds a beat while the receiver stalls.
// Depends on qce_pkg.
module qce_out_reg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  qce_pkg::result_t           res,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic [qce_pkg::BYTE_W-1:0] out_ch,
    output logic [1:0]                 status
);
    import qce_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] ch_reg;
    logic [1:0]        status_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = res.emit;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.emit)
        begin
            ch_reg     <= res.ch;
            status_reg <= res.status;
        end
    end

    assign out_valid = valid_reg;
    assign out_ch    = ch_reg;
    assign status    = status_reg;

endmodule

// ===== sv/qce_checker.sv =====
// Port-level checks for the quoted column extractor, bound to the top level.
// Depends on qce_pkg and quoted_column_extractor_core.
module qce_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [qce_pkg::BYTE_W-1:0]   out_ch,
    input logic [1:0]                   status,
    input logic                         cfg_ready
);
    import qce_pkg::*;

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_ch) && $stable(status))
        else $error("stalled result beat changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_BYTE) || (status == ST_FOUND) || (status == ST_ERROR))
        else $error("undefined status code");

    // Closing beats carry a zero byte
    a_close_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_BYTE) |-> (out_ch == '0))
        else $error("closing beat with nonzero byte");

    // Input stall only rises while the output side is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind quoted_column_extractor_core qce_checker u_qce_checker (.*);

// ===== test/quoted_column_extractor_core_tb.sv =====
// Self-checking bench for quoted_column_extractor_core: text lines in, column beats out.
// Depends on qce_pkg and the core; a built-in column predictor supplies expected beats.
`timescale 1ns / 100ps

module quoted_column_extractor_core_tb;

    import qce_pkg::*;

    localparam int unsigned NUM_DELIMS     = 4;
    localparam int          RESET_CYCLES   = 12;
    // A result passes the input and result registers; leave margin before writes.
    localparam int          DRAIN_CYCLES   = 6;
    localparam int          WATCHDOG_LIMIT = 2000;
    // Index outside the register map; the core must drop writes to it.
    localparam logic [INDEX_W-1:0] REG_SPARE = 3'd7;

    typedef logic [BYTE_W-1:0] slot_arr_t [NUM_SLOTS];

    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic              eol;
    } line_item_t;

    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic [1:0]        status;
    } col_beat_t;

    typedef enum int {
        LN_NOISE,
        LN_MISSING,
        LN_EMPTY_QUOTE,
        LN_OPEN_QUOTE,
        LN_CLEAN
    } line_kind_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [BYTE_W-1:0]    ch          = '0;
    logic                 end_of_line = 1'b0;
    logic                 out_valid;
    logic                 out_stall   = 1'b0;
    logic [BYTE_W-1:0]    out_ch;
    logic [1:0]           status;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [INDEX_W-1:0]   cfg_index   = '0;
    logic [BYTE_W-1:0]    cfg_data    = '0;

    // Bytes waiting for the driver, and column beats waiting for the core.
    line_item_t line_bytes [$];
    col_beat_t  col_due [$];

    // Predictor copy of the registers and scan state.
    logic [BYTE_W-1:0]  tgt_reg   = RST_TARGET_COLUMN;
    slot_arr_t          delim_reg = '{RST_DELIM_A, RST_DELIM_B, RST_DELIM_C, RST_DELIM_D};
    phase_t             scan_ph   = PH_SKIP;
    logic [COUNT_W-1:0] col_cnt   = '0;

    // Settings the line generator works against.
    int        plan_tgt   = RST_TARGET_COLUMN;
    slot_arr_t plan_slots = '{RST_DELIM_A, RST_DELIM_B, RST_DELIM_C, RST_DELIM_D};

    bit in_taken = 1'b0;
    bit quiet    = 1'b0;
    int in_gap   = 0;
    int out_gap  = 0;
    int pushed_cnt  = 0;
    int err_cnt     = 0;
    int dead_cycles = 0;
    int n_in_beats  = 0;
    int n_lines     = 0;
    int n_col_bytes = 0;
    int n_found     = 0;
    int n_error     = 0;
    int n_writes    = 0;

    quoted_column_extractor_core #(
        .NUM_DELIMS (NUM_DELIMS)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .ch          (ch),
        .end_of_line (end_of_line),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_ch      (out_ch),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // Only the first NUM_DELIMS slots take part; a zero slot never matches.
    function automatic logic is_delim(input logic [BYTE_W-1:0] c, input slot_arr_t slots);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_DELIMS; i++)
        begin
            if (i < NUM_SLOTS && slots[i] != '0 && slots[i] == c)
                hit = 1'b1;
        end
        return hit;
    endfunction

    // Advance the scan by one accepted beat; queue the column beat it causes.
    task automatic predict_column(input logic [BYTE_W-1:0] c, input logic eol);
        logic      dl;
        logic      qt;
        bit        has;
        col_beat_t r;
        dl       = is_delim(c, delim_reg);
        qt       = (c == QUOTE_BYTE);
        has      = 1'b0;
        r.ch     = '0;
        r.status = ST_BYTE;
        case (scan_ph) inside
            PH_USKIP, PH_QSKIP:
            begin
                // A column ahead of the target is open: the line end means it is missing.
                if (eol)
                begin
                    has      = 1'b1;
                    r.status = ST_ERROR;
                end
                else if ((scan_ph == PH_USKIP) ? dl : qt)
                begin
                    col_cnt = col_cnt + 1'b1;
                    scan_ph = PH_SKIP;
                end
            end
            PH_QFIRST, PH_QIN:
            begin
                has = 1'b1;
                if (eol)
                    r.status = ST_ERROR;
                else if (qt)
                begin
                    // Closing quote right after the opening one: empty column.
                    r.status = (scan_ph == PH_QFIRST) ? ST_ERROR : ST_FOUND;
                    scan_ph  = PH_DONE;
                end
                else
                begin
                    r.ch    = c;
                    scan_ph = PH_QIN;
                end
            end
            PH_TCOL:
            begin
                has = 1'b1;
                if (eol)
                    r.status = ST_FOUND;
                else if (dl)
                begin
                    r.status = ST_FOUND;
                    scan_ph  = PH_DONE;
                end
                else
                    r.ch = c;
            end
            PH_DONE:
            begin
            end
            default:
            begin
                if (eol)
                begin
                    has      = 1'b1;
                    r.status = ST_ERROR;
                end
                else if (dl)
                    scan_ph = PH_SKIP;
                else if (col_cnt == tgt_reg)
                begin
                    if (qt)
                        scan_ph = PH_QFIRST;
                    else
                    begin
                        has     = 1'b1;
                        r.ch    = c;
                        scan_ph = PH_TCOL;
                    end
                end
                else
                    scan_ph = qt ? PH_QSKIP : PH_USKIP;
            end
        endcase
        // Every line end restarts the scan, whatever the phase.
        if (eol)
        begin
            scan_ph = PH_SKIP;
            col_cnt = '0;
            n_lines++;
        end
        if (has)
        begin
            col_due.push_back(r);
            case (r.status)
                ST_BYTE:  n_col_bytes++;
                ST_FOUND: n_found++;
                default:  n_error++;
            endcase
        end
    endtask

    // ---------------------------------------------------------------------
    // Line generation against the planned settings
    // ---------------------------------------------------------------------
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        line_item_t it;
        it.ch  = b;
        it.eol = 1'b0;
        line_bytes.push_back(it);
        pushed_cnt++;
    endtask

    // ch rides along with random content; the core must ignore it.
    task automatic push_eol();
        line_item_t it;
        it.ch  = 8'($urandom_range(0, 255));
        it.eol = 1'b1;
        line_bytes.push_back(it);
        pushed_cnt++;
    endtask

    function automatic bit has_delims();
        bit any;
        any = 1'b0;
        for (int i = 0; i < NUM_DELIMS && i < NUM_SLOTS; i++)
        begin
            if (plan_slots[i] != '0)
                any = 1'b1;
        end
        return any;
    endfunction

    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_delim(b, plan_slots) || b == QUOTE_BYTE);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_delim();
        logic [BYTE_W-1:0] live [$];
        for (int i = 0; i < NUM_DELIMS && i < NUM_SLOTS; i++)
        begin
            if (plan_slots[i] != '0)
                live.push_back(plan_slots[i]);
        end
        if (live.size() == 0)
            return plain_byte();
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    // Quote bytes may sit inside an unquoted column after its first byte.
    function automatic logic [BYTE_W-1:0] inner_byte();
        if ($urandom_range(0, 7) == 0 && !is_delim(QUOTE_BYTE, plan_slots))
            return QUOTE_BYTE;
        return plain_byte();
    endfunction

    // Delimiters inside quotes must not split the column.
    function automatic logic [BYTE_W-1:0] quoted_byte();
        logic [BYTE_W-1:0] b;
        b = plain_byte();
        if ($urandom_range(0, 3) == 0)
        begin
            b = pick_delim();
            if (b == QUOTE_BYTE)
                b = plain_byte();
        end
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] noise_byte();
        int roll;
        roll = $urandom_range(0, 5);
        if (roll < 2)
            return pick_delim();
        if (roll == 2)
            return QUOTE_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Build one line. Most lines are well formed around the target column;
    // the rest end early, carry empty or open quotes, or are plain noise.
    // tight keeps the content of every column to at most one byte for very large targets.
    task automatic gen_line(input bit tight);
        line_kind_t kind;
        int         roll;
        int         ncols;
        int         spec_col;
        int         len;
        int         i;
        int         k;
        bit         quoted;
        bit         prev_quoted;
        bit         live;
        live     = has_delims();
        roll     = $urandom_range(0, 19);
        spec_col = -1;
        kind     = (roll < 3) ? LN_NOISE : (roll == 3) ? LN_MISSING :
                   (roll == 4) ? LN_EMPTY_QUOTE : (roll == 5) ? LN_OPEN_QUOTE : LN_CLEAN;
        if (kind == LN_NOISE)
        begin
            len = $urandom_range(0, 12);
            for (k = 0; k < len; k++)
                push_byte(noise_byte());
            push_eol();
            return;
        end
        case (kind)
            LN_MISSING:
                ncols = $urandom_range(0, plan_tgt);
            LN_EMPTY_QUOTE:
            begin
                spec_col = plan_tgt;
                ncols    = plan_tgt + 1 + $urandom_range(0, 1);
            end
            LN_OPEN_QUOTE:
            begin
                spec_col = $urandom_range(0, plan_tgt);
                ncols    = spec_col + 1;
            end
            default:
                ncols = plan_tgt + 1 + $urandom_range(0, 1);
        endcase
        if (live && !tight)
            repeat ($urandom_range(0, 2)) push_byte(pick_delim());
        prev_quoted = 1'b0;
        for (i = 0; i < ncols; i++)
        begin
            // Sometimes glue a column straight onto a closing quote.
            if (i > 0 && live && !(prev_quoted && $urandom_range(0, 3) == 0))
                repeat (tight ? 1 : $urandom_range(1, 3)) push_byte(pick_delim());
            quoted = (i == spec_col) || ($urandom_range(0, 2) == 0);
            if (i == spec_col && kind == LN_EMPTY_QUOTE)
            begin
                push_byte(QUOTE_BYTE);
                push_byte(QUOTE_BYTE);
            end
            else if (quoted)
            begin
                push_byte(QUOTE_BYTE);
                len = $urandom_range((i == plan_tgt) ? 1 : 0, tight ? 1 : 5);
                for (k = 0; k < len; k++)
                    push_byte(quoted_byte());
                if (i == spec_col)
                    break;
                push_byte(QUOTE_BYTE);
            end
            else
            begin
                len = $urandom_range(1, tight ? 1 : 5);
                for (k = 0; k < len; k++)
                    push_byte((k == 0) ? plain_byte() : inner_byte());
            end
            prev_quoted = quoted;
        end
        if (live && $urandom_range(0, 3) == 0)
            push_byte(pick_delim());
        push_eol();
    endtask

    // ---------------------------------------------------------------------
    // Phase control
    // ---------------------------------------------------------------------
    // Hold until the driver is empty and every column beat is back, then
    // let the pipeline settle, since a trailing beat may cause no result.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (line_bytes.size() != 0 || in_valid || col_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic run_phase(input logic [BYTE_W-1:0] tgt, input logic [BYTE_W-1:0] da,
                             input logic [BYTE_W-1:0] db, input logic [BYTE_W-1:0] dc,
                             input logic [BYTE_W-1:0] dd, input int budget);
        int start;
        wait_drained();
        write_reg(REG_TARGET_COLUMN, tgt);
        write_reg(REG_DELIM_A, da);
        write_reg(REG_DELIM_B, db);
        write_reg(REG_DELIM_C, dc);
        write_reg(REG_DELIM_D, dd);
        write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
        @(negedge clk);
        cfg_valid  <= 1'b0;
        plan_tgt   = tgt;
        plan_slots = '{da, db, dc, dd};
        start      = pushed_cnt;
        while (pushed_cnt - start < budget)
            gen_line(1'b0);
    endtask

    // ---------------------------------------------------------------------
    // Stimulus: directed lines on reset settings, then random phases
    // ---------------------------------------------------------------------
    initial
    begin : stimulus
        logic [BYTE_W-1:0] rnd_slot [NUM_SLOTS];
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Target column 0, space and tab as delimiters.
        // Plain column closed by the line end.
        push_byte("a"); push_byte("b"); push_eol();
        // Quoted column with a space inside; the line end after it is silent.
        push_byte(QUOTE_BYTE); push_byte("x"); push_byte(" "); push_byte("y");
        push_byte(QUOTE_BYTE); push_eol();
        // Empty quotes.
        push_byte(QUOTE_BYTE); push_byte(QUOTE_BYTE); push_eol();
        // Line ends inside the quote.
        push_byte(QUOTE_BYTE); push_byte("a"); push_byte("b"); push_eol();
        // Only delimiters: the column never starts.
        push_byte(" "); push_eol();
        // Zero byte and all-ones byte are ordinary text.
        push_byte(8'h00); push_byte(8'hFF); push_eol();
        // Quote inside an unquoted column, column closed by a tab.
        push_byte("a"); push_byte(QUOTE_BYTE); push_byte(8'h09); push_eol();

        // Random phases; each starts from an idle core, which also gives the
        // sender a full pause until every column beat has come back.
        run_phase(8'd1, 8'd32, 8'd9, 8'd44, 8'd0, 120);
        run_phase(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 60);
        run_phase(8'd3, QUOTE_BYTE, 8'd255, 8'd0, 8'd1, 110);
        run_phase(8'd2, 8'd255, 8'd0, 8'd59, 8'd124, 110);
        // Large target: one-byte columns keep these lines short.
        run_phase(8'd30, 8'd32, 8'd0, 8'd0, 8'd0, 0);
        gen_line(1'b1);
        gen_line(1'b1);
        foreach (rnd_slot[i])
            rnd_slot[i] = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        run_phase(8'($urandom_range(0, 4)), rnd_slot[0], rnd_slot[1], rnd_slot[2],
                  rnd_slot[3], 100);
        // Closing stretch at full rate on both sides.
        quiet = 1'b1;
        run_phase(8'd1, 8'd32, 8'd9, 8'd0, 8'd0, 100);

        wait_drained();
        $display("Covered %0d lines over %0d input beats and %0d register writes.",
                 n_lines, n_in_beats, n_writes);
        $display("Checked %0d column bytes, %0d found closings, %0d error closings.",
                 n_col_bytes, n_found, n_error);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Input driver: advance on the falling edge, hold a stalled beat
    // ---------------------------------------------------------------------
    always @(negedge clk)
    begin : input_driver
        line_item_t it;
        if (rst_n)
        begin
            if (in_valid && !in_taken)
            begin
                // Beat not taken yet: hold valid and payload.
            end
            else if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap   = in_gap - 1;
            end
            else if (!quiet && line_bytes.size() != 0 && $urandom_range(0, 15) == 0)
            begin
                // Open an idle burst that begins with this cycle.
                in_valid <= 1'b0;
                in_gap   = $urandom_range(0, 13);
            end
            else if (line_bytes.size() != 0)
            begin
                it = line_bytes.pop_front();
                in_valid    <= 1'b1;
                ch          <= it.ch;
                end_of_line <= it.eol;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Output side: stall in random bursts.
    always @(negedge clk)
    begin : stall_driver
        if (rst_n)
        begin
            if (out_gap > 0)
            begin
                out_stall <= 1'b1;
                out_gap   = out_gap - 1;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                out_stall <= 1'b1;
                out_gap   = $urandom_range(0, 13);
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: sample every handshake on the rising edge
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        col_beat_t due;
        bit        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                n_writes++;
                case (cfg_index)
                    REG_TARGET_COLUMN: tgt_reg      = cfg_data;
                    REG_DELIM_A:       delim_reg[0] = cfg_data;
                    REG_DELIM_B:       delim_reg[1] = cfg_data;
                    REG_DELIM_C:       delim_reg[2] = cfg_data;
                    REG_DELIM_D:       delim_reg[3] = cfg_data;
                    default:           ;
                endcase
            end

            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                n_in_beats++;
                predict_column(ch, end_of_line);
            end

            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                if (col_due.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: unexpected beat: expected none, actual out_ch %02h status %0d",
                             $time, out_ch, status);
                end
                else
                begin
                    due = col_due.pop_front();
                    if (out_ch !== due.ch)
                    begin
                        err_cnt++;
                        $display("%0t: out_ch mismatch: expected %02h, actual %02h",
                                 $time, due.ch, out_ch);
                    end
                    if (status !== due.status)
                    begin
                        err_cnt++;
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, due.status, status);
                    end
                end
            end

            // Drop the run if no channel moves for too long.
            dead_cycles = moved ? 0 : dead_cycles + 1;
            if (dead_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog: no beat for %0d cycles, %0d column beats pending",
                         $time, dead_cycles, col_due.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

endmodule

// ===== quoted_column_extractor_core.f =====
sv/qce_pkg.sv
sv/qce_delim_match.sv
sv/qce_scan.sv
sv/qce_out_reg.sv
sv/quoted_column_extractor_core.sv
sv/qce_checker.sv
test/quoted_column_extractor_core_tb.sv
